/* rtl/dct4_pkg.sv */
// Shared types and fixed field widths for the dominant color top-4 block.
// No dependencies; imported by every module of the block.
package dct4_pkg;

    localparam int COLOUR_W  = 24;  // {blue, green, red}, red in the low byte
    localparam int RANK_W    = 2;
    localparam int IDX_OUT_W = 8;
    localparam int CNT_OUT_W = 24;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 64;

    typedef logic [COLOUR_W-1:0] colour_t;

    // Pixel moving down the cell chain
    typedef struct packed {
        logic    valid;
        colour_t colour;
    } pix_t;

endpackage

/* rtl/dominant_color_top4_unit.sv */
// Dominant color finder top level: chain of histogram cells plus ranked top-K list.
// Depends on dct4_pkg, dct4_cell, dct4_topk.
//
// Pixels stream in at one item per cycle while s_tready is high; each pixel walks a row
// of MAX_COLOURS cells, one cell per cycle, where it bumps the matching entry's saturating
// count or claims the first empty cell (or is dropped and flags overflow). After a pixel
// with tlast, s_tready stays low while the chain drains, then while the entries shift out
// of cell 0 into the top-K insertion list (this also empties the table for the next
// frame), then TOP_K result items are sent in rank order, one per cycle when m_tready
// is high. Entry valid bits clear on reset, so no clearing pass is needed.
module dominant_color_top4_unit
    import dct4_pkg::*;
#(
    parameter int MAX_COLOURS = 256,
    parameter int COUNT_BITS  = 24,
    parameter int TOP_K       = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // pixel_red, pixel_green, pixel_blue
    input  logic                 s_tlast,   // last_pixel
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // rank, entry_index, top_red, top_green,
                                            // top_blue, pixel_count, table_overflow
    output logic                 m_tuser,   // rank_valid
    output logic                 m_tlast    // last_result
);

    localparam int IDX_W   = $clog2(MAX_COLOURS);
    localparam int RK_W    = (TOP_K > 1) ? $clog2(TOP_K) : 1;
    localparam int M_PAD_W = M_TDATA_W - (RANK_W + IDX_OUT_W + COLOUR_W + CNT_OUT_W + 1);

    localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(MAX_COLOURS - 1);
    localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);
    localparam logic [RK_W-1:0]  RK_LAST   = RK_W'(TOP_K - 1);
    localparam logic [RK_W-1:0]  RK_ONE    = RK_W'(1);

    localparam logic [1:0] ST_RUN    = 2'd0;
    localparam logic [1:0] ST_DRAIN  = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_REPORT = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [RK_W-1:0]  rk_reg, rk_next;
    logic             ovf_reg, ovf_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;
    logic                 m_tlast_reg;

    logic s_accept, shift_en, out_load;

    pix_t                  pix_chain [MAX_COLOURS+1];
    logic                  ent_valid [MAX_COLOURS+1];
    colour_t               ent_colour[MAX_COLOURS+1];
    logic [COUNT_BITS-1:0] ent_count [MAX_COLOURS+1];

    logic                  head_valid;
    logic [COUNT_BITS-1:0] head_count;
    logic [IDX_W-1:0]      head_idx;
    colour_t               head_colour;

    assign s_tready = (state_reg == ST_RUN);
    assign s_accept = s_tvalid && s_tready;
    assign shift_en = (state_reg == ST_SCAN);
    assign out_load = (state_reg == ST_REPORT) && (!m_tvalid_reg || m_tready);

    assign pix_chain[0] = '{valid: s_accept, colour: s_tdata[COLOUR_W-1:0]};

    // empty entry shifted in behind the last cell during the scan
    assign ent_valid[MAX_COLOURS]  = 1'b0;
    assign ent_colour[MAX_COLOURS] = '0;
    assign ent_count[MAX_COLOURS]  = '0;

    for (genvar i = 0; i < MAX_COLOURS; i++) begin : g_cell
        dct4_cell #(
            .COUNT_BITS(COUNT_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (shift_en),
            .pix_in    (pix_chain[i]),
            .pix_out   (pix_chain[i+1]),
            .nb_valid  (ent_valid[i+1]),
            .nb_colour (ent_colour[i+1]),
            .nb_count  (ent_count[i+1]),
            .ent_valid (ent_valid[i]),
            .ent_colour(ent_colour[i]),
            .ent_count (ent_count[i])
        );
    end

    dct4_topk #(
        .TOP_K     (TOP_K),
        .COUNT_BITS(COUNT_BITS),
        .IDX_W     (IDX_W)
    ) u_topk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ins_en     (shift_en && ent_valid[0]),
        .ins_count  (ent_count[0]),
        .ins_idx    (cnt_reg),
        .ins_colour (ent_colour[0]),
        .pop_en     (out_load),
        .head_valid (head_valid),
        .head_count (head_count),
        .head_idx   (head_idx),
        .head_colour(head_colour)
    );

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        rk_next       = rk_reg;
        ovf_next      = ovf_reg;
        m_tvalid_next = m_tvalid_reg;

        // an unclaimed pixel falling off the end of the chain was dropped
        if (pix_chain[MAX_COLOURS].valid) begin
            ovf_next = 1'b1;
        end

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_RUN: begin
                if (s_accept && s_tlast) begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN: begin
                cnt_next = cnt_reg + IDX_ONE;
                if (cnt_reg == LAST_CELL) begin
                    state_next = ST_SCAN;
                    cnt_next   = '0;
                end
            end
            ST_SCAN: begin
                // cell 0 holds entry cnt_reg this cycle
                cnt_next = cnt_reg + IDX_ONE;
                if (cnt_reg == LAST_CELL) begin
                    state_next = ST_REPORT;
                    rk_next    = '0;
                end
            end
            ST_REPORT: begin
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    rk_next       = rk_reg + RK_ONE;
                    if (rk_reg == RK_LAST) begin
                        state_next = ST_RUN;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_RUN;
            cnt_reg      <= '0;
            rk_reg       <= '0;
            ovf_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rk_reg       <= rk_next;
            ovf_reg      <= ovf_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {{M_PAD_W{1'b0}},
                            ovf_reg,
                            head_valid ? CNT_OUT_W'(head_count) : {CNT_OUT_W{1'b0}},
                            head_valid ? head_colour : {COLOUR_W{1'b0}},
                            head_valid ? IDX_OUT_W'(head_idx) : {IDX_OUT_W{1'b0}},
                            RANK_W'(rk_reg)};
            m_tuser_reg <= head_valid;
            m_tlast_reg <= (rk_reg == RK_LAST);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // no pixel may still fall off the end of the chain once the entries start shifting out
    a_scan_chain_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !pix_chain[MAX_COLOURS].valid)
        else $error("pixel still in flight during report scan");

    // a valid rank must follow a valid rank
    a_rank_valid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (rk_reg != '0) && head_valid) |-> m_tuser_reg)
        else $error("valid rank after an invalid rank");

    // overflow flag starts clean for the next frame
    a_ovf_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && (rk_reg == RK_LAST)) |=> !ovf_reg)
        else $error("overflow flag not cleared after report");

    // input closes after the last pixel is accepted and stays closed until the last result is loaded for output
    a_ready_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tlast) |=> !s_tready)
        else $error("input accepted during report");

endmodule

/* rtl/dct4_cell.sv */
// One histogram cell: holds one table entry (color, count) and one pixel stage.
// Depends on dct4_pkg.
module dct4_cell
    import dct4_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  shift_en,
    input  pix_t                  pix_in,
    output pix_t                  pix_out,
    input  logic                  nb_valid,
    input  colour_t               nb_colour,
    input  logic [COUNT_BITS-1:0] nb_count,
    output logic                  ent_valid,
    output colour_t               ent_colour,
    output logic [COUNT_BITS-1:0] ent_count
);

    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic                  valid_reg, valid_next;
    colour_t               colour_reg, colour_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  pix_valid_reg, pix_valid_next;
    colour_t               pix_colour_reg, pix_colour_next;
    logic                  hit, take;

    always_comb begin
        hit  = pix_in.valid && valid_reg && (colour_reg == pix_in.colour);
        take = pix_in.valid && !valid_reg;

        valid_next  = valid_reg;
        colour_next = colour_reg;
        count_next  = count_reg;
        if (shift_en) begin
            // report scan: entries move toward cell 0, empties come in at the far end
            valid_next  = nb_valid;
            colour_next = nb_colour;
            count_next  = nb_count;
        end else if (take) begin
            valid_next  = 1'b1;
            colour_next = pix_in.colour;
            count_next  = CNT_ONE;
        end else if (hit && (count_reg != CNT_MAX)) begin
            count_next = count_reg + CNT_ONE;
        end

        pix_valid_next  = pix_in.valid && !hit && !take;
        pix_colour_next = pix_in.colour;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= 1'b0;
            pix_valid_reg <= 1'b0;
        end else begin
            valid_reg     <= valid_next;
            pix_valid_reg <= pix_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        colour_reg     <= colour_next;
        count_reg      <= count_next;
        pix_colour_reg <= pix_colour_next;
    end

    assign pix_out    = '{valid: pix_valid_reg, colour: pix_colour_reg};
    assign ent_valid  = valid_reg;
    assign ent_colour = colour_reg;
    assign ent_count  = count_reg;

endmodule

/* rtl/dct4_topk.sv */
// Ranked insertion list: keeps the TOP_K largest counts seen during a scan,
// earlier entries winning ties, and pops them out in rank order. Depends on dct4_pkg.
module dct4_topk
    import dct4_pkg::*;
#(
    parameter int TOP_K      = 4,
    parameter int COUNT_BITS = 24,
    parameter int IDX_W      = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  ins_en,
    input  logic [COUNT_BITS-1:0] ins_count,
    input  logic [IDX_W-1:0]      ins_idx,
    input  colour_t               ins_colour,
    input  logic                  pop_en,
    output logic                  head_valid,
    output logic [COUNT_BITS-1:0] head_count,
    output logic [IDX_W-1:0]      head_idx,
    output colour_t               head_colour
);

    logic                  bv_reg  [TOP_K];
    logic                  bv_next [TOP_K];
    logic [COUNT_BITS-1:0] bc_reg  [TOP_K];
    logic [COUNT_BITS-1:0] bc_next [TOP_K];
    logic [IDX_W-1:0]      bi_reg  [TOP_K];
    logic [IDX_W-1:0]      bi_next [TOP_K];
    colour_t               bcol_reg  [TOP_K];
    colour_t               bcol_next [TOP_K];
    logic                  beat    [TOP_K];

    always_comb begin
        // list is sorted descending with empties at the tail, so beat is 0..0 1..1
        for (int k = 0; k < TOP_K; k++) begin
            beat[k] = !bv_reg[k] || (ins_count > bc_reg[k]);
        end

        bv_next   = bv_reg;
        bc_next   = bc_reg;
        bi_next   = bi_reg;
        bcol_next = bcol_reg;

        if (pop_en) begin
            for (int k = 0; k < TOP_K - 1; k++) begin
                bv_next[k]   = bv_reg[k+1];
                bc_next[k]   = bc_reg[k+1];
                bi_next[k]   = bi_reg[k+1];
                bcol_next[k] = bcol_reg[k+1];
            end
            bv_next[TOP_K-1] = 1'b0;
        end else if (ins_en) begin
            if (beat[0]) begin
                bv_next[0]   = 1'b1;
                bc_next[0]   = ins_count;
                bi_next[0]   = ins_idx;
                bcol_next[0] = ins_colour;
            end
            for (int k = 1; k < TOP_K; k++) begin
                if (beat[k]) begin
                    if (beat[k-1]) begin
                        bv_next[k]   = bv_reg[k-1];
                        bc_next[k]   = bc_reg[k-1];
                        bi_next[k]   = bi_reg[k-1];
                        bcol_next[k] = bcol_reg[k-1];
                    end else begin
                        bv_next[k]   = 1'b1;
                        bc_next[k]   = ins_count;
                        bi_next[k]   = ins_idx;
                        bcol_next[k] = ins_colour;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < TOP_K; k++) begin
                bv_reg[k] <= 1'b0;
            end
        end else begin
            bv_reg <= bv_next;
        end
    end

    always_ff @(posedge aclk) begin
        bc_reg   <= bc_next;
        bi_reg   <= bi_next;
        bcol_reg <= bcol_next;
    end

    assign head_valid  = bv_reg[0];
    assign head_count  = bc_reg[0];
    assign head_idx    = bi_reg[0];
    assign head_colour = bcol_reg[0];

endmodule

/* dv/tb_dominant_color_top4_unit.sv */
// Self-checking testbench for dominant_color_top4_unit: pixel frames in, ranked top-4 colors out.
// A directed table runs first, then random frames that include one overflowing the table.
// Depends on dct4_pkg and the dominant_color_top4_unit RTL.
module tb_dominant_color_top4_unit;
    import dct4_pkg::*;

    localparam int MAX_COLOURS = 256;
    localparam int TOP_K       = 4;
    localparam int RAND_ITEMS  = 400;
    localparam int QUIET_AFTER = 340;

    typedef struct packed {
        logic [1:0]  rank;
        logic [7:0]  idx;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [23:0] count;
        logic        valid;
        logic        overflow;
        logic        last;
    } rank_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
        logic       typed;  // results are known by inspection: lone pixel in a fresh frame
    } pixel_row_t;

    localparam pixel_row_t DIRECTED [19] = '{
        '{8'h00, 8'h00, 8'h00, 1'b1, 1'b1},
        '{8'hff, 8'hff, 8'hff, 1'b1, 1'b1},
        // colors one channel apart, three-way tie at count 2
        '{8'h10, 8'h20, 8'h30, 1'b0, 1'b0},
        '{8'h10, 8'h20, 8'h31, 1'b0, 1'b0},
        '{8'h10, 8'h20, 8'h31, 1'b0, 1'b0},
        '{8'h10, 8'h21, 8'h30, 1'b0, 1'b0},
        '{8'h10, 8'h21, 8'h30, 1'b0, 1'b0},
        '{8'h10, 8'h20, 8'h30, 1'b0, 1'b0},
        '{8'h11, 8'h20, 8'h30, 1'b0, 1'b0},
        '{8'hff, 8'h00, 8'hff, 1'b1, 1'b0},
        // two colors only: ranks 2 and 3 missing
        '{8'h01, 8'h80, 8'h00, 1'b0, 1'b0},
        '{8'h00, 8'h01, 8'h80, 1'b0, 1'b0},
        '{8'h01, 8'h80, 8'h00, 1'b1, 1'b0},
        // later entries outrank earlier ones
        '{8'h7f, 8'h7f, 8'h7f, 1'b0, 1'b0},
        '{8'h80, 8'h80, 8'h80, 1'b0, 1'b0},
        '{8'h80, 8'h80, 8'h80, 1'b0, 1'b0},
        '{8'h00, 8'hff, 8'h00, 1'b0, 1'b0},
        '{8'h00, 8'hff, 8'h00, 1'b0, 1'b0},
        '{8'h00, 8'hff, 8'h00, 1'b1, 1'b0}
    };

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    // histogram mirror
    colour_t     hist_colour [MAX_COLOURS];
    logic [23:0] hist_count [MAX_COLOURS];
    int          hist_used = 0;
    bit          hist_overflow = 1'b0;
    rank_item_t  ranked [TOP_K];

    rank_item_t  pending_ranks [$];
    int          mismatches = 0;
    bit          quiet = 1'b0;

    dominant_color_top4_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #50_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Counts one pixel; on the last pixel fills ranked[] and clears the histogram.
    function automatic int tally_pixel(colour_t c, bit last);
        int hit;
        int best;
        bit taken [MAX_COLOURS];
        hit = -1;
        for (int i = 0; i < hist_used; i++)
            if (hit < 0 && hist_colour[i] == c) hit = i;
        if (hit >= 0) begin
            if (hist_count[hit] != 24'hffffff) hist_count[hit] = hist_count[hit] + 24'd1;
        end else if (hist_used < MAX_COLOURS) begin
            hist_colour[hist_used] = c;
            hist_count[hist_used] = 24'd1;
            hist_used++;
        end else begin
            hist_overflow = 1'b1;
        end
        if (!last) return 0;

        taken = '{default: 1'b0};
        for (int r = 0; r < TOP_K; r++) begin
            best = -1;
            // strict compare keeps the lowest index on a tie
            for (int i = 0; i < hist_used; i++)
                if (!taken[i] && (best < 0 || hist_count[i] > hist_count[best])) best = i;
            ranked[r] = '0;
            ranked[r].rank = r[1:0];
            ranked[r].overflow = hist_overflow;
            ranked[r].last = (r == TOP_K - 1);
            if (best >= 0) begin
                taken[best] = 1'b1;
                ranked[r].idx = best[7:0];
                ranked[r].red = hist_colour[best][7:0];
                ranked[r].green = hist_colour[best][15:8];
                ranked[r].blue = hist_colour[best][23:16];
                ranked[r].count = hist_count[best];
                ranked[r].valid = 1'b1;
            end
        end
        hist_used = 0;
        hist_overflow = 1'b0;
        foreach (hist_count[i]) hist_count[i] = '0;
        return TOP_K;
    endfunction

    task automatic send_pixel(input colour_t c, input bit last, input bit typed);
        int n;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        n = tally_pixel(c, last);
        for (int r = 0; r < n; r++) begin
            if (typed) begin
                // lone pixel in a cleared table: rank 0 only, entry 0, count 1
                ranked[r] = '0;
                ranked[r].rank = r[1:0];
                ranked[r].last = (r == TOP_K - 1);
                if (r == 0) begin
                    ranked[r].red = c[7:0];
                    ranked[r].green = c[15:8];
                    ranked[r].blue = c[23:16];
                    ranked[r].count = 24'd1;
                    ranked[r].valid = 1'b1;
                end
            end
            pending_ranks.push_back(ranked[r]);
        end
    endtask

    // stimulus
    initial begin
        colour_t palette [6];
        colour_t base;
        colour_t c;
        int      sent;
        int      frame_no;
        int      len;
        int      npal;
        while (!aresetn) @(posedge aclk);

        foreach (DIRECTED[i])
            send_pixel({DIRECTED[i].blue, DIRECTED[i].green, DIRECTED[i].red},
                       DIRECTED[i].last, DIRECTED[i].typed);

        sent = 0;
        frame_no = 0;
        while (sent < RAND_ITEMS) begin
            if (frame_no == 2) begin
                // fill the table, drop new colors, keep counting old ones, drop the last pixel
                base = colour_t'($urandom);
                for (int i = 0; i < MAX_COLOURS + 8; i++)
                    send_pixel(colour_t'(base + i), 1'b0, 1'b0);
                for (int i = 0; i < 6; i++)
                    send_pixel(colour_t'(base + $urandom_range(0, MAX_COLOURS - 1)), 1'b0, 1'b0);
                send_pixel(colour_t'(base + MAX_COLOURS + 20), 1'b1, 1'b0);
                sent += MAX_COLOURS + 15;
            end else begin
                len = $urandom_range(1, 16);
                npal = $urandom_range(1, 6);
                for (int i = 0; i < npal; i++) palette[i] = colour_t'($urandom);
                for (int k = 0; k < len; k++) begin
                    c = palette[$urandom_range(0, npal - 1)];
                    case ($urandom_range(0, 9))
                        0, 1, 2: c = colour_t'($urandom);
                        3:       c = c ^ (24'd1 << $urandom_range(0, 23));  // near miss
                        default: ;
                    endcase
                    send_pixel(c, k == len - 1, 1'b0);
                end
                sent += len;
            end
            frame_no++;
            quiet = (sent >= QUIET_AFTER);
        end
        s_tvalid <= 1'b0;

        while (pending_ranks.size() != 0) @(posedge aclk);
        repeat (2 * MAX_COLOURS + 32) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // result-side backpressure
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        rank_item_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_ranks.size() == 0) begin
                $error("rank item with no expectation waiting: tdata %h", m_tdata);
                mismatches++;
            end else begin
                want = pending_ranks.pop_front();
                check_field("rank", 32'(want.rank), 32'(m_tdata[1:0]));
                check_field("entry_index", 32'(want.idx), 32'(m_tdata[9:2]));
                check_field("top_red", 32'(want.red), 32'(m_tdata[17:10]));
                check_field("top_green", 32'(want.green), 32'(m_tdata[25:18]));
                check_field("top_blue", 32'(want.blue), 32'(m_tdata[33:26]));
                check_field("pixel_count", 32'(want.count), 32'(m_tdata[57:34]));
                check_field("table_overflow", 32'(want.overflow), 32'(m_tdata[58]));
                check_field("rank_valid", 32'(want.valid), 32'(m_tuser));
                check_field("last_result", 32'(want.last), 32'(m_tlast));
            end
        end
    end

endmodule
